/* src/sitda_pkg.sv */
// Shared types and constants for the signed integer to decimal ASCII converter.
// Depends on nothing; every other file in src imports it.
package sitda_pkg;

	// Width of the signed input value.
	localparam int VALUE_WIDTH = 32;

	// Width of an output character code.
	localparam int CHAR_W = 6;

	// ASCII codes, truncated to the character width.
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

	// Number of decimal digits needed for the largest magnitude, 2**(width-1).
	function automatic int digit_count(input int width);
		longint unsigned mag_max;
		longint unsigned pow10;
		int n;
		mag_max = 64'd1 << (width - 1);
		pow10 = 64'd10;
		n = 1;
		while (pow10 <= mag_max && n < 20) begin
			n++;
			pow10 = pow10 * 64'd10;
		end
		return n;
	endfunction

	localparam int NDIG      = digit_count(VALUE_WIDTH);
	localparam int DIG_IDX_W = $clog2(NDIG);
	localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture a new value and clear the digits
		logic shift;       // one double-dabble step
		logic find_lead;   // locate the leading nonzero digit
		logic emit_sign;   // put a minus sign into the output register
		logic emit_digit;  // put the current digit into the output register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_bit;    // the current shift is the final one
		logic neg;         // the captured value is negative
		logic idx_zero;    // the current digit is the least significant one
		logic out_free;    // the output register can take a character
	} dp_sts_t;

endpackage

/* src/sitda_ctrl.sv */
// Controller state machine of the decimal ASCII converter.
// Depends on sitda_pkg for the command and status structs.
module sitda_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sitda_pkg::dp_sts_t sts,
	output sitda_pkg::dp_cmd_t cmd
);
	import sitda_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CONV   = 3'd1;
	localparam logic [2:0] ST_LEAD   = 3'd2;
	localparam logic [2:0] ST_SIGN   = 3'd3;
	localparam logic [2:0] ST_DIGITS = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.shift = 1'b1;
				if (sts.last_bit) begin
					state_d = ST_LEAD;
				end
			end
			ST_LEAD: begin
				cmd.find_lead = 1'b1;
				state_d = sts.neg ? ST_SIGN : ST_DIGITS;
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				if (sts.out_free) begin
					cmd.emit_digit = 1'b1;
					if (sts.idx_zero) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A new item is taken only when the previous one is fully handed to the output.
	assign in_stall = (state_q != ST_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/sitda_dp.sv */
// Datapath of the decimal ASCII converter: magnitude, BCD digits and output register.
// Depends on sitda_pkg for widths, ASCII codes and the command and status structs.
module sitda_dp (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] value,
	input  sitda_pkg::dp_cmd_t                       cmd,
	output sitda_pkg::dp_sts_t                       sts,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [sitda_pkg::CHAR_W-1:0]             character,
	output logic                                     last
);
	import sitda_pkg::*;

	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag_in;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [3:0]             bcd_q [NDIG];
	logic [3:0]             adj   [NDIG];
	logic [3:0]             nxt   [NDIG];
	logic [DIG_IDX_W-1:0]   idx_q;
	logic [DIG_IDX_W-1:0]   lead;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;
	logic                   out_valid_q;

	// Magnitude of the input; the most negative value wraps to its own unsigned magnitude.
	assign raw    = value;
	assign mag_in = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

	// Double-dabble step: correct each digit of five or more, then shift one bit in.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
		nxt[0] = {adj[0][2:0], mag_q[VALUE_WIDTH-1]};
		for (int i = 1; i < NDIG; i++) begin
			nxt[i] = {adj[i][2:0], adj[i-1][3]};
		end
	end

	// Position of the highest nonzero digit, or the lowest digit when all are zero.
	always_comb begin
		lead = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i] != 4'd0) begin
				lead = DIG_IDX_W'(i);
			end
		end
	end

	// Conversion registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q     <= mag_in;
			neg_q     <= raw[VALUE_WIDTH-1];
			bit_cnt_q <= BIT_CNT_W'(VALUE_WIDTH - 1);
			for (int i = 0; i < NDIG; i++) begin
				bcd_q[i] <= 4'd0;
			end
		end else if (cmd.shift) begin
			mag_q     <= mag_q << 1;
			bit_cnt_q <= bit_cnt_q - 1'b1;
			for (int i = 0; i < NDIG; i++) begin
				bcd_q[i] <= nxt[i];
			end
		end
		if (cmd.find_lead) begin
			idx_q <= lead;
		end else if (cmd.emit_digit) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= ASCII_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= ASCII_ZERO + {2'b00, bcd_q[idx_q]};
			last_q <= (idx_q == '0);
		end
	end

	// Output valid: set by a new character, cleared once the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.last_bit = (bit_cnt_q == '0);
	assign sts.neg      = neg_q;
	assign sts.idx_zero = (idx_q == '0);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

/* src/signed_int_to_decimal_ascii.sv */
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitda_pkg, sitda_ctrl and sitda_dp.
//
//  channel  handshake             payload               meaning
//  in       in_valid / in_stall   value[31:0] signed    one integer per item
//  out      out_valid / out_stall character[5:0], last  one ASCII character per item
//
// An input item is captured, shifted through VALUE_WIDTH double-dabble steps and
// searched for its leading digit; then one character is emitted per cycle while
// the output does not stall.
// Reset clears the controller and the output valid; no other register is reset.
// A stalled output holds the current character and pauses emission; the next
// input item is taken as soon as the final character is in the output register.
module signed_int_to_decimal_ascii (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] value,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [sitda_pkg::CHAR_W-1:0]             character,
	output logic                                     last
);
	import sitda_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencing of conversion and emission.
	sitda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Magnitude, BCD digits and output register.
	sitda_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	// Only one datapath command is active in any cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.shift, cmd.find_lead, cmd.emit_sign, cmd.emit_digit}))
		else $error("more than one datapath command at once");

	// An accepted item keeps the input stalled while it is converted.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after an accepted item");

	// A character that is not the last of its run means the block is still busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> in_stall)
		else $error("input open while a run is unfinished");

	// A sign emission shows a minus sign that never ends the run.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_sign |=> (out_valid && character == ASCII_MINUS && !last))
		else $error("minus sign emitted incorrectly");

endmodule

/* verif/signed_int_to_decimal_ascii_tb.sv */
// Testbench for signed_int_to_decimal_ascii: drives signed integers and checks
// the decimal ASCII characters that come back against a behavioral predictor or known text.
// Depends on sitda_pkg and the RTL under src.
module signed_int_to_decimal_ascii_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sitda_pkg::*;

	localparam int DIRECTED_ROWS = 20;
	localparam int RANDOM_ITEMS = 190;
	localparam int CALM_FIRST = 80;
	localparam int CALM_LAST = 130;
	localparam int HOLD_AT_ITEM = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_DIGITS = 20;
	localparam logic [VALUE_WIDTH-1:0] DECIMAL_BASE = 10;

	// One expected output character.
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} ascii_char_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic signed [VALUE_WIDTH-1:0] value = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [CHAR_W-1:0]             character;
	logic                          last;

	ascii_char_t expected_chars[$];
	int          error_count = 0;
	int          items_sent = 0;
	int          cycle_count = 0;
	bit          calm = 1'b0;
	bit          hold_done = 1'b0;

	logic signed [VALUE_WIDTH-1:0] directed_value [DIRECTED_ROWS];
	string                         directed_text [DIRECTED_ROWS];

	signed_int_to_decimal_ascii i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	// Free-running clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Works out the decimal text of one value and queues its characters.
	function automatic void predict_decimal_text(input logic signed [VALUE_WIDTH-1:0] v);
		logic [VALUE_WIDTH-1:0] mag;
		logic [3:0]             digits [MAX_DIGITS];
		logic                   neg;
		int                     nd;
		neg = v[VALUE_WIDTH-1];
		// The magnitude is unsigned, so the most negative value needs no special path.
		mag = neg ? (~v + 1'b1) : v;
		nd = 0;
		do begin
			digits[nd] = 4'(mag % DECIMAL_BASE);
			nd++;
			mag = mag / DECIMAL_BASE;
		end while (mag != 0 && nd < MAX_DIGITS);
		if (neg)
			expected_chars.push_back('{character: ASCII_MINUS, last: 1'b0});
		for (int i = nd - 1; i >= 0; i--)
			expected_chars.push_back('{character: ASCII_ZERO + CHAR_W'(digits[i]),
				last: (i == 0)});
	endfunction

	// Queues the characters of a text that is known by inspection.
	function automatic void queue_known_text(input string text);
		byte c;
		for (int i = 0; i < text.len(); i++) begin
			c = text[i];
			expected_chars.push_back('{character: c[CHAR_W-1:0], last: (i == text.len() - 1)});
		end
	endfunction

	// Random value, weighted toward short texts, digit-count boundaries and extremes.
	function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
		logic signed [VALUE_WIDTH-1:0] v;
		int unsigned                   scale;
		int                            k;
		case ($urandom_range(0, 4))
			0: v = $urandom;
			1: v = $urandom_range(0, 999);
			2: begin
				scale = 1;
				k = $urandom_range(0, 9);
				repeat (k) scale = scale * 10;
				v = scale + $urandom_range(0, 2) - 1;
			end
			3: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}} + $urandom_range(0, 3);
			default: v = $urandom_range(0, 99999);
		endcase
		if ($urandom_range(0, 1) == 1)
			v = -v;
		return v;
	endfunction

	// Offers one item, idling at random first, and queues its expected text once taken.
	task automatic offer_value(input logic signed [VALUE_WIDTH-1:0] v, input string text);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (text.len() == 0)
			predict_decimal_text(v);
		else
			queue_known_text(text);
	endtask

	// Receiver stall: random stalls, none while calm, and one long hold-off to back the block up.
	initial begin : drive_out_stall
		int hold;
		forever begin
			@(negedge clk);
			if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
				hold_done = 1'b1;
				for (hold = 0; hold < HOLD_CYCLES; hold++) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
			end
			out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 24);
		end
	end

	// Compares every accepted character with the oldest expectation.
	always @(posedge clk) begin : check_chars
		ascii_char_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected character: character=%0d last=%0d", character, last);
				error_count++;
			end else begin
				want = expected_chars.pop_front();
				if (character !== want.character) begin
					$error("character: expected %0d, actual %0d", want.character, character);
					error_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, last);
					error_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("signed_int_to_decimal_ascii verification failed");
			$finish;
		end
	end

	// Reset, directed rows, random items, drain and verdict.
	initial begin : run_stimulus
		directed_value = '{0, 1, -1, 32'h7FFFFFFF, 32'h80000000, 32'h80000001,
			9, 10, -9, -10, 99, 100, 999999999, 1000000000, -1000000000,
			32'h55555555, 32'hAAAAAAAA, 123456789, -123456789, 0};
		directed_text = '{"0", "1", "-1", "2147483647", "-2147483648", "-2147483647",
			"", "", "", "", "", "", "", "1000000000", "",
			"", "", "", "", "0"};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++)
			offer_value(directed_value[i], directed_text[i]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= CALM_FIRST && i < CALM_LAST);
			offer_value(pick_value(), "");
		end
		calm = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("signed_int_to_decimal_ascii verification clean");
		else
			$display("signed_int_to_decimal_ascii verification failed");
		$finish;
	end

endmodule
